/* src/mvsm_pkg.sv */
`default_nettype none
package mvsm_pkg;

   localparam int VOICES       = 64;
   localparam int SAMPLE_WORDS = 65536;
   localparam int VIDX_W       = 6;
   localparam int VI_W         = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int SADDR_W      = $clog2(SAMPLE_WORDS);
   localparam int ACC_W        = 18 + $clog2(VOICES);
   localparam logic [19:0] ONE_Q16 = 20'h10000;

   localparam logic [3:0] REQ_TICK   = 4'd0;
   localparam logic [3:0] REQ_SWRITE = 4'd1;
   localparam logic [3:0] REQ_SETUP  = 4'd2;
   localparam logic [3:0] REQ_PLAY   = 4'd3;
   localparam logic [3:0] REQ_STOP   = 4'd4;
   localparam logic [3:0] REQ_PAUSE  = 4'd5;
   localparam logic [3:0] REQ_SPEED  = 4'd6;
   localparam logic [3:0] REQ_QUERY  = 4'd7;
   localparam logic [3:0] REQ_GROUP  = 4'd8;

   localparam logic [1:0] SCOPE_ONE   = 2'd0;
   localparam logic [1:0] SCOPE_ALL   = 2'd1;
   localparam logic [1:0] SCOPE_OTHER = 2'd2;

   typedef struct packed {
      logic [3:0]         req_type;
      logic [5:0]         voice;
      logic [5:0]         last_voice;
      logic [1:0]         scope;
      logic [15:0]        sample_addr;
      logic signed [15:0] sample_value;
      logic [15:0]        base_addr;
      logic [15:0]        length;
      logic [8:0]         volume;
      logic               loop;
      logic [19:0]        speed;
      logic               pause_flag;
   } mvsm_req_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic [5:0]         started_voice;
      logic               is_playing;
   } mvsm_rsp_type;

   typedef struct packed {
      logic [15:0] base;
      logic [15:0] length;
      logic [8:0]  volume;
      logic        loop;
      logic [19:0] speed;
      logic [31:0] position;
   } mvsm_voice_type;

   localparam int ENTRY_W = $bits(mvsm_voice_type);

endpackage
`default_nettype wire

/* src/multi_voice_sample_mixer_core.sv */
`default_nettype none
// Multi-voice sample playback mixer.
// Request channel: drive req_item and raise start while busy is low; the
// transaction is taken at that clock edge and busy rises on the next cycle.
// Result channel: every transaction gives one result, shown on rsp_item for
// exactly one cycle with rsp_valid high. The receiver cannot stall it.
// Commands (sample write, stop, pause, query) answer straight from the command
// state; setup, play and speed do a read-modify-write of the voice memory;
// group play first scans its voice range for one that is not playing. A tick
// walks all voices, one per cycle when idle; for each active voice it reads the
// voice memory, then the sample memory, and multiplies and accumulates for left
// and right.
// A new transaction may start in the cycle in which the result is shown.
// Reset clears the playing and paused flags and marks every voice entry
// unwritten; an unwritten entry reads as zero with unit speed, so no
// clearing pass is needed. Sample memory is undefined until written.
module multi_voice_sample_mixer_core
   import mvsm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire mvsm_req_type req_item,
   output logic              rsp_valid,
   output mvsm_rsp_type      rsp_item
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CMD  = 4'd1;
   localparam logic [3:0] S_SCAN = 4'd2;
   localparam logic [3:0] S_RD   = 4'd3;
   localparam logic [3:0] S_WR   = 4'd4;
   localparam logic [3:0] S_VRD  = 4'd5;
   localparam logic [3:0] S_LAT  = 4'd6;
   localparam logic [3:0] S_ADDR = 4'd7;
   localparam logic [3:0] S_MUL  = 4'd8;
   localparam logic [3:0] S_ACC  = 4'd9;

   logic [3:0]  state_ff, state_in;
   mvsm_req_type req_ff, req_in;
   logic [VOICES-1:0] playing_ff, playing_in, paused_ff, paused_in, valid_ff, valid_in;
   logic [VI_W-1:0]   v_ff, v_in, tgt_ff, tgt_in;
   logic [5:0]        idx_ff, idx_in, started_ff, started_in;
   mvsm_voice_type    ent_ff, ent_in;
   logic [31:0]       pos_ff, pos_in;
   logic [32:0]       sum_ff, sum_in;
   logic              ge_ff, ge_in, stop_ff, stop_in, slot_ff, slot_in;
   logic signed [25:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] lacc_ff, lacc_in, racc_ff, racc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   mvsm_rsp_type      rsp_ff, rsp_in;

   logic              vram_we;
   logic [VI_W-1:0]   vram_waddr, vram_raddr;
   mvsm_voice_type    vram_wdata, vram_rdata, vram_ent;
   logic [ENTRY_W-1:0] vram_rraw;
   logic              sram_we;
   logic [SADDR_W-1:0] sram_waddr, sram_raddr;
   logic [15:0]       sram_rdata;

   logic              exists, idx_in_range, idx_end;
   logic [VOICES-1:0] hit;
   logic [31:0]       sa_rd, sa_wr;
   logic [32:0]       end_pos;
   logic signed [16:0] contrib;
   logic signed [ACC_W-1:0] acc_next;
   logic [VI_W-1:0]   idx_v;

   mvsm_ram #(.WIDTH(ENTRY_W), .DEPTH(VOICES)) u_voice_ram (
      .clock(clock), .we(vram_we), .waddr(vram_waddr), .wdata(vram_wdata),
      .raddr(vram_raddr), .rdata(vram_rraw)
   );

   mvsm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_sample_ram (
      .clock(clock), .we(sram_we), .waddr(sram_waddr), .wdata(req_ff.sample_value),
      .raddr(sram_raddr), .rdata(sram_rdata)
   );

   function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] a);
      if (a > ACC_W'(32767)) begin
         return 16'sh7fff;
      end else if (a < -ACC_W'(32768)) begin
         return -16'sh8000;
      end
      return a[15:0];
   endfunction

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      vram_rdata = mvsm_voice_type'(vram_rraw);
      vram_ent   = vram_rdata;
      if (!valid_ff[vram_raddr]) begin
         vram_ent = '0;
         vram_ent.speed = ONE_Q16;
      end
   end

   assign exists       = (32'(req_ff.voice) < VOICES);
   assign idx_in_range = (32'(idx_ff) < VOICES);
   assign idx_end      = (idx_ff == req_ff.last_voice) || (32'(idx_ff) >= VOICES - 1);
   assign idx_v        = VI_W'(idx_ff);
   assign sa_rd        = 32'(ent_ff.base) + 32'(pos_ff[31:16]);
   assign sa_wr        = 32'(req_ff.sample_addr);
   assign end_pos      = {1'b0, ent_ff.length, 16'h0000};
   assign contrib      = 17'(prod_ff >>> 9);
   assign acc_next     = (slot_ff ? racc_ff : lacc_ff) + ACC_W'(contrib);

   always_comb begin
      for (int i = 0; i < VOICES; i++) begin
         case (req_ff.scope)
            SCOPE_ONE:   hit[i] = (32'(req_ff.voice) == i);
            SCOPE_ALL:   hit[i] = 1'b1;
            SCOPE_OTHER: hit[i] = (32'(req_ff.voice) != i);
            default:     hit[i] = 1'b0;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      playing_in   = playing_ff;
      paused_in    = paused_ff;
      valid_in     = valid_ff;
      v_in         = v_ff;
      tgt_in       = tgt_ff;
      idx_in       = idx_ff;
      started_in   = started_ff;
      ent_in       = ent_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      ge_in        = ge_ff;
      stop_in      = stop_ff;
      slot_in      = slot_ff;
      prod_in      = prod_ff;
      lacc_in      = lacc_ff;
      racc_in      = racc_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      vram_we      = 1'b0;
      vram_waddr   = tgt_ff;
      vram_wdata   = ent_ff;
      vram_raddr   = tgt_ff;
      sram_we      = 1'b0;
      sram_waddr   = SADDR_W'(sa_wr);
      sram_raddr   = SADDR_W'(sa_rd);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = S_CMD;
            end
         end
         S_CMD: begin
            rsp_in     = '0;
            tgt_in     = VI_W'(req_ff.voice);
            started_in = '0;
            case (req_ff.req_type)
               REQ_TICK: begin
                  v_in     = '0;
                  lacc_in  = '0;
                  racc_in  = '0;
                  state_in = S_VRD;
               end
               REQ_SWRITE: begin
                  sram_we      = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               REQ_SETUP, REQ_PLAY, REQ_SPEED: begin
                  if (exists) begin
                     state_in = S_RD;
                  end else begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               REQ_STOP: begin
                  playing_in   = playing_ff & ~hit;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               REQ_PAUSE: begin
                  paused_in    = req_ff.pause_flag ? (paused_ff | hit) : (paused_ff & ~hit);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               REQ_QUERY: begin
                  rsp_in.is_playing = exists && playing_ff[VI_W'(req_ff.voice)];
                  rsp_valid_in      = 1'b1;
                  state_in          = S_IDLE;
               end
               REQ_GROUP: begin
                  idx_in = req_ff.voice;
                  if (req_ff.last_voice >= req_ff.voice) begin
                     state_in = S_SCAN;
                  end else if (exists) begin
                     started_in = req_ff.voice;
                     state_in   = S_RD;
                  end else begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            if (idx_in_range && !playing_ff[idx_v]) begin
               tgt_in     = idx_v;
               started_in = idx_ff;
               state_in   = S_RD;
            end else if (idx_end) begin
               if (exists) begin
                  started_in = req_ff.voice;
                  state_in   = S_RD;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               idx_in = idx_ff + 6'd1;
            end
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            vram_wdata = vram_ent;
            case (req_ff.req_type)
               REQ_SETUP: begin
                  vram_wdata.base     = req_ff.base_addr;
                  vram_wdata.length   = req_ff.length;
                  vram_wdata.volume   = req_ff.volume;
                  vram_wdata.loop     = req_ff.loop;
                  vram_wdata.position = '0;
                  playing_in[tgt_ff]  = 1'b0;
               end
               REQ_SPEED: begin
                  vram_wdata.speed = req_ff.speed;
               end
               default: begin
                  vram_wdata.position = '0;
                  playing_in[tgt_ff]  = 1'b1;
               end
            endcase
            vram_we              = 1'b1;
            valid_in[tgt_ff]     = 1'b1;
            rsp_in.started_voice = started_ff;
            rsp_valid_in         = 1'b1;
            state_in             = S_IDLE;
         end
         S_VRD: begin
            vram_raddr = v_ff;
            if (playing_ff[v_ff] && !paused_ff[v_ff]) begin
               state_in = S_LAT;
            end else if (32'(v_ff) == VOICES - 1) begin
               rsp_in.left_out  = sat16(lacc_ff);
               rsp_in.right_out = sat16(racc_ff);
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end else begin
               v_in = v_ff + 1'b1;
            end
         end
         S_LAT: begin
            vram_raddr = v_ff;
            ent_in     = vram_ent;
            pos_in     = vram_ent.position;
            slot_in    = 1'b0;
            state_in   = S_ADDR;
         end
         S_ADDR: begin
            sum_in   = 33'(pos_ff) + 33'(ent_ff.speed);
            ge_in    = ((33'(pos_ff) + 33'(ent_ff.speed)) >= end_pos);
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in = $signed(sram_rdata) * $signed({1'b0, ent_ff.volume});
            stop_in = ge_ff && !ent_ff.loop;
            if (!ge_ff) begin
               pos_in = sum_ff[31:0];
            end else if (ent_ff.loop) begin
               pos_in = 32'(sum_ff - end_pos);
            end else begin
               pos_in = '0;
            end
            state_in = S_ACC;
         end
         S_ACC: begin
            if (slot_ff) begin
               racc_in = acc_next;
            end else begin
               lacc_in = acc_next;
            end
            if (!stop_ff && !slot_ff) begin
               slot_in  = 1'b1;
               state_in = S_ADDR;
            end else begin
               if (stop_ff) begin
                  playing_in[v_ff] = 1'b0;
               end
               vram_we             = 1'b1;
               vram_waddr          = v_ff;
               vram_wdata.position = pos_ff;
               if (32'(v_ff) == VOICES - 1) begin
                  rsp_in.left_out  = sat16(slot_ff ? lacc_ff : acc_next);
                  rsp_in.right_out = sat16(slot_ff ? acc_next : racc_ff);
                  rsp_valid_in     = 1'b1;
                  state_in         = S_IDLE;
               end else begin
                  v_in     = v_ff + 1'b1;
                  state_in = S_VRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         playing_ff   <= '0;
         paused_ff    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         playing_ff   <= playing_in;
         paused_ff    <= paused_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      v_ff       <= v_in;
      tgt_ff     <= tgt_in;
      idx_ff     <= idx_in;
      started_ff <= started_in;
      ent_ff     <= ent_in;
      pos_ff     <= pos_in;
      sum_ff     <= sum_in;
      ge_ff      <= ge_in;
      stop_ff    <= stop_in;
      slot_ff    <= slot_in;
      prod_ff    <= prod_in;
      lacc_ff    <= lacc_in;
      racc_ff    <= racc_in;
      rsp_ff     <= rsp_in;
   end
endmodule
`default_nettype wire

/* src/mvsm_ram.sv */
`default_nettype none
module mvsm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

/* tb/multi_voice_sample_mixer_core_test.sv */
`default_nettype none
module multi_voice_sample_mixer_core_test;
   import mvsm_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int RANDOM_ITEMS = 1350;

   typedef struct {
      mvsm_req_type req;
      bit           typed;
      mvsm_rsp_type rsp;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   mvsm_req_type req_item;
   logic         rsp_valid;
   mvsm_rsp_type rsp_item;

   multi_voice_sample_mixer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // mixer shadow state
   logic [15:0] smem [SAMPLE_WORDS];
   bit          smem_written [SAMPLE_WORDS];
   logic [15:0] v_base [VOICES];
   logic [15:0] v_len [VOICES];
   logic [8:0]  v_vol [VOICES];
   bit          v_loop [VOICES];
   logic [19:0] v_speed [VOICES];
   logic [31:0] v_pos [VOICES];
   bit          v_play [VOICES];
   bit          v_pause [VOICES];

   mvsm_rsp_type pending_rsp [$];
   logic [15:0]  frame_reads [$];
   int           fail_count = 0;
   int           cycles = 0;
   bit           no_idle;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // walk all voices for one frame; without commit only collect read addresses
   task automatic mix_frame(input bit commit, output logic signed [15:0] lo,
                            output logic signed [15:0] ro);
      logic [31:0] pos [VOICES];
      bit          on [VOICES];
      int          sums [2];
      int          v, k, prod;
      bit          stopped;
      logic [15:0] a;
      logic [32:0] np, lim;
      begin
         pos = v_pos;
         on = v_play;
         sums[0] = 0;
         sums[1] = 0;
         for (v = 0; v < VOICES; v++) begin
            if (!on[v] || v_pause[v]) continue;
            stopped = 1'b0;
            for (k = 0; k < 2 && !stopped; k++) begin
               a = v_base[v] + pos[v][31:16];
               if (!commit) frame_reads.push_back(a);
               prod = int'($signed(smem[a])) * int'(v_vol[v]);
               sums[k] += prod >>> 9;
               np = {1'b0, pos[v]} + v_speed[v];
               lim = {1'b0, v_len[v], 16'h0000};
               if (np >= lim) begin
                  if (v_loop[v]) begin
                     np = np - lim;
                  end else begin
                     np = '0;
                     on[v] = 1'b0;
                     stopped = 1'b1;
                  end
               end
               pos[v] = np[31:0];
            end
         end
         if (commit) begin
            v_pos = pos;
            v_play = on;
         end
         lo = (sums[0] > 32767) ? 16'sd32767 : (sums[0] < -32768) ? -16'sd32768 : sums[0][15:0];
         ro = (sums[1] > 32767) ? 16'sd32767 : (sums[1] < -32768) ? -16'sd32768 : sums[1][15:0];
      end
   endtask

   task automatic apply_request(input mvsm_req_type r, output mvsm_rsp_type e);
      int  v;
      bit  hit, found;
      logic signed [15:0] lo, ro;
      begin
         e = '0;
         case (r.req_type)
            REQ_TICK: begin
               mix_frame(1'b1, lo, ro);
               e.left_out = lo;
               e.right_out = ro;
            end
            REQ_SWRITE: begin
               smem[r.sample_addr] = r.sample_value;
               smem_written[r.sample_addr] = 1'b1;
            end
            REQ_SETUP: begin
               v_base[r.voice] = r.base_addr;
               v_len[r.voice] = r.length;
               v_vol[r.voice] = r.volume;
               v_loop[r.voice] = r.loop;
               v_pos[r.voice] = '0;
               v_play[r.voice] = 1'b0;
            end
            REQ_PLAY: begin
               v_pos[r.voice] = '0;
               v_play[r.voice] = 1'b1;
            end
            REQ_STOP, REQ_PAUSE: begin
               for (v = 0; v < VOICES; v++) begin
                  hit = (r.scope == SCOPE_ALL) || (r.scope == SCOPE_ONE && v == r.voice) ||
                        (r.scope == SCOPE_OTHER && v != r.voice);
                  if (!hit) continue;
                  if (r.req_type == REQ_STOP) begin
                     v_pos[v] = '0;
                     v_play[v] = 1'b0;
                  end else begin
                     v_pause[v] = r.pause_flag;
                  end
               end
            end
            REQ_SPEED: v_speed[r.voice] = r.speed;
            REQ_QUERY: e.is_playing = v_play[r.voice];
            REQ_GROUP: begin
               found = 1'b0;
               for (v = r.voice; v <= r.last_voice && v < VOICES && !found; v++) begin
                  if (!v_play[v]) begin
                     v_pos[v] = '0;
                     v_play[v] = 1'b1;
                     e.started_voice = 6'(v);
                     found = 1'b1;
                  end
               end
               if (!found) begin
                  v_pos[r.voice] = '0;
                  v_play[r.voice] = 1'b1;
                  e.started_voice = r.voice;
               end
            end
            default: ;
         endcase
      end
   endtask

   task automatic issue(input mvsm_req_type r, input bit typed, input mvsm_rsp_type t);
      mvsm_req_type w;
      mvsm_rsp_type e;
      logic signed [15:0] lo, ro;
      logic [15:0] a;
      begin
         // fill any sample word this frame would read before it is written
         if (r.req_type == REQ_TICK) begin
            frame_reads.delete();
            mix_frame(1'b0, lo, ro);
            while (frame_reads.size() > 0) begin
               a = frame_reads.pop_front();
               if (!smem_written[a]) begin
                  w = '0;
                  w.req_type = REQ_SWRITE;
                  w.sample_addr = a;
                  w.sample_value = 16'($urandom());
                  issue(w, 1'b0, '0);
               end
            end
         end
         @(negedge clock);
         if (!no_idle && $urandom_range(0, 99) < 28) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         req_item = r;
         start = 1'b1;
         do begin
            @(posedge clock);
         end while (busy);
         apply_request(r, e);
         pending_rsp.push_back(typed ? t : e);
      end
   endtask

   task automatic drain;
      begin
         @(negedge clock);
         start = 1'b0;
         while (pending_rsp.size() > 0) @(negedge clock);
      end
   endtask

   function automatic mvsm_req_type random_request();
      mvsm_req_type r;
      logic [127:0] raw;
      int pick;
      begin
         raw = {$urandom(), $urandom(), $urandom(), $urandom()};
         r = raw[$bits(mvsm_req_type)-1:0];
         pick = $urandom_range(0, 99);
         if (pick < 30)      r.req_type = REQ_TICK;
         else if (pick < 45) r.req_type = REQ_SWRITE;
         else if (pick < 57) r.req_type = REQ_SETUP;
         else if (pick < 67) r.req_type = REQ_PLAY;
         else if (pick < 73) r.req_type = REQ_STOP;
         else if (pick < 79) r.req_type = REQ_PAUSE;
         else if (pick < 85) r.req_type = REQ_SPEED;
         else if (pick < 91) r.req_type = REQ_QUERY;
         else if (pick < 97) r.req_type = REQ_GROUP;
         else                r.req_type = 4'($urandom_range(9, 15));
         if ($urandom_range(0, 9) < 8) r.voice = 6'($urandom_range(0, 7));
         if ($urandom_range(0, 9) < 8) r.last_voice = 6'(r.voice + $urandom_range(0, 4));
         if ($urandom_range(0, 9) < 9) r.sample_addr = 16'($urandom_range(0, 511));
         if ($urandom_range(0, 9) < 9) r.base_addr = 16'($urandom_range(0, 255));
         if ($urandom_range(0, 9) < 9) r.length = 16'($urandom_range(0, 64));
         if ($urandom_range(0, 9) < 8) r.volume = 9'($urandom_range(0, 256));
         if ($urandom_range(0, 9) < 8) r.speed = 20'($urandom_range(0, 20'h40000));
         if ($urandom_range(0, 9) < 7) r.pause_flag = 1'b0;
         random_request = r;
      end
   endfunction

   function automatic mvsm_req_type mk(input logic [3:0] kind, input int vc, input int lv,
                                       input logic [1:0] sc, input int a, input int val);
      mvsm_req_type r;
      begin
         r = '0;
         r.req_type = kind;
         r.voice = 6'(vc);
         r.last_voice = 6'(lv);
         r.scope = sc;
         r.sample_addr = 16'(a);
         r.sample_value = 16'(val);
         r.base_addr = 16'(a);
         r.length = 16'(val);
         r.volume = 9'd256;
         r.speed = ONE_Q16;
         mk = r;
      end
   endfunction

   function automatic mvsm_rsp_type out(input int lo, input int ro, input int sv, input bit p);
      mvsm_rsp_type e;
      begin
         e.left_out = 16'(lo);
         e.right_out = 16'(ro);
         e.started_voice = 6'(sv);
         e.is_playing = p;
         out = e;
      end
   endfunction

   always @(posedge clock) begin
      mvsm_rsp_type e;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("multi_voice_sample_mixer_core test failed");
         $finish;
      end else if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected transaction %p", $time, rsp_item);
            fail_count <= fail_count + 1;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_item.left_out !== e.left_out || rsp_item.right_out !== e.right_out ||
                rsp_item.started_voice !== e.started_voice ||
                rsp_item.is_playing !== e.is_playing) begin
               $display("%0t mismatch: expected %p actual %p", $time, e, rsp_item);
               fail_count <= fail_count + 1;
            end
         end
      end
   end

   initial begin
      stim_row_type rows [$];
      stim_row_type row;
      mvsm_req_type r;
      int i, v;

      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      no_idle = 1'b0;
      for (i = 0; i < SAMPLE_WORDS; i++) begin
         smem[i] = '0;
         smem_written[i] = 1'b0;
      end
      for (v = 0; v < VOICES; v++) begin
         v_base[v] = '0;
         v_len[v] = '0;
         v_vol[v] = '0;
         v_loop[v] = 1'b0;
         v_speed[v] = ONE_Q16;
         v_pos[v] = '0;
         v_play[v] = 1'b0;
         v_pause[v] = 1'b0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      rows.push_back('{mk(REQ_QUERY, 0, 0, SCOPE_ONE, 0, 0), 1, out(0, 0, 0, 0)});
      rows.push_back('{mk(REQ_TICK, 0, 0, SCOPE_ONE, 0, 0), 1, out(0, 0, 0, 0)});
      rows.push_back('{mk(REQ_SWRITE, 0, 0, SCOPE_ONE, 0, 32767), 1, out(0, 0, 0, 0)});
      rows.push_back('{mk(REQ_SWRITE, 0, 0, SCOPE_ONE, 1, -32768), 1, out(0, 0, 0, 0)});
      rows.push_back('{mk(REQ_SWRITE, 0, 0, SCOPE_ONE, 65535, -32768), 1, out(0, 0, 0, 0)});
      rows.push_back('{mk(REQ_SETUP, 0, 0, SCOPE_ONE, 0, 2), 1, out(0, 0, 0, 0)});
      rows.push_back('{mk(REQ_PLAY, 0, 0, SCOPE_ONE, 0, 0), 1, out(0, 0, 0, 0)});
      rows.push_back('{mk(REQ_QUERY, 0, 0, SCOPE_ONE, 0, 0), 1, out(0, 0, 0, 1)});
      rows.push_back('{mk(REQ_TICK, 0, 0, SCOPE_ONE, 0, 0), 1, out(16383, -16384, 0, 0)});
      rows.push_back('{mk(REQ_QUERY, 0, 0, SCOPE_ONE, 0, 0), 1, out(0, 0, 0, 0)});
      rows.push_back('{mk(REQ_GROUP, 5, 3, SCOPE_ONE, 0, 0), 1, out(0, 0, 5, 0)});
      rows.push_back('{mk(REQ_GROUP, 5, 63, SCOPE_ONE, 0, 0), 1, out(0, 0, 6, 0)});
      rows.push_back('{mk(REQ_SETUP, 63, 0, SCOPE_ONE, 65535, 65535), 0, '0});
      rows.push_back('{mk(REQ_SETUP, 62, 0, SCOPE_ONE, 0, 0), 0, '0});
      r = mk(REQ_SPEED, 63, 0, SCOPE_ONE, 0, 0);
      r.speed = 20'hFFFFF;
      rows.push_back('{r, 0, '0});
      rows.push_back('{mk(REQ_PLAY, 63, 0, SCOPE_ONE, 0, 0), 0, '0});
      rows.push_back('{mk(REQ_PLAY, 0, 0, SCOPE_ONE, 0, 0), 0, '0});
      rows.push_back('{mk(REQ_TICK, 0, 0, SCOPE_ONE, 0, 0), 0, '0});
      r = mk(REQ_PAUSE, 63, 0, SCOPE_OTHER, 0, 0);
      r.pause_flag = 1'b1;
      rows.push_back('{r, 0, '0});
      rows.push_back('{mk(REQ_TICK, 0, 0, SCOPE_ONE, 0, 0), 0, '0});
      rows.push_back('{mk(REQ_STOP, 0, 0, 2'd3, 0, 0), 1, out(0, 0, 0, 0)});
      rows.push_back('{mk(REQ_PAUSE, 0, 0, SCOPE_ALL, 0, 0), 1, out(0, 0, 0, 0)});
      rows.push_back('{mk(REQ_STOP, 0, 0, SCOPE_ALL, 0, 0), 1, out(0, 0, 0, 0)});
      rows.push_back('{mk(4'd9, 0, 0, SCOPE_ONE, 0, 0), 1, out(0, 0, 0, 0)});
      rows.push_back('{mk(4'd15, 0, 0, SCOPE_ONE, 0, 0), 1, out(0, 0, 0, 0)});

      foreach (rows[i]) begin
         row = rows[i];
         issue(row.req, row.typed, row.rsp);
      end

      // seed the common sample region
      for (i = 0; i < 320; i++) begin
         r = mk(REQ_SWRITE, 0, 0, SCOPE_ONE, i, 0);
         r.sample_value = 16'($urandom());
         if (!smem_written[i]) issue(r, 1'b0, '0);
      end

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         no_idle = (i >= 600 && i < 900);
         if (i == 400 || i == 1200) drain();
         issue(random_request(), 1'b0, '0);
      end
      drain();
      repeat (600) @(posedge clock);
      if (fail_count == 0) begin
         $display("multi_voice_sample_mixer_core test passed");
      end else begin
         $display("multi_voice_sample_mixer_core test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
